// ----- rtl/rog_pkg.sv -----
// shared types, constants and helpers of the rotation outlier gate
package rog_pkg;

    // element format
    localparam int ELEM_W  = 16;
    localparam int FRAC    = 14;
    localparam int PROD_W  = 2 * ELEM_W;
    localparam int MSUM_W  = PROD_W + 2;
    localparam int TSUM_W  = PROD_W + 4;
    localparam int LIMIT_W = 17;
    localparam int NELEM   = 9;

    typedef logic signed [ELEM_W-1:0] t_elem;
    typedef t_elem t_mat [NELEM];

    // saturation bounds at matrix-sum width
    localparam logic signed [MSUM_W-1:0] EMAX = {{(MSUM_W-ELEM_W+1){1'b0}}, {(ELEM_W-1){1'b1}}};
    localparam logic signed [MSUM_W-1:0] EMIN = ~EMAX;
    localparam logic signed [MSUM_W-1:0] HALF = MSUM_W'(longint'(1) << (FRAC - 1));

    // 1.0, saturated when the format cannot hold it
    localparam longint ONE_L = (FRAC < ELEM_W - 1) ? (longint'(1) << FRAC)
                                                   : ((longint'(1) << (ELEM_W - 1)) - 1);
    localparam t_elem ONE_Q = ELEM_W'(ONE_L);

    // gate states
    typedef enum logic [3:0] {
        MODE_UNINIT = 4'b0001,
        MODE_TRACK  = 4'b0010,
        MODE_HOLD   = 4'b0100,
        MODE_REACQ  = 4'b1000
    } t_mode;

    // operation codes
    localparam logic [1:0] OP_OBS    = 2'd0;
    localparam logic [1:0] OP_REACQ  = 2'd1;
    localparam logic [1:0] OP_SRST   = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // result codes
    localparam logic [1:0] PUB_HELD  = 2'd0;
    localparam logic [1:0] PUB_TRACK = 2'd1;
    localparam logic [1:0] PUB_REACQ = 2'd2;
    localparam logic [1:0] REJ_NONE  = 2'd0;
    localparam logic [1:0] REJ_INVAL = 2'd1;
    localparam logic [1:0] REJ_JUMP  = 2'd2;
    localparam logic [1:0] GS_UNINIT = 2'd0;
    localparam logic [1:0] GS_TRACK  = 2'd1;
    localparam logic [1:0] GS_HOLD   = 2'd2;
    localparam logic [1:0] GS_REACQ  = 2'd3;

    // register indexes
    localparam logic [1:0] REG_LIMIT  = 2'd0;
    localparam logic [1:0] REG_BUDGET = 2'd1;
    localparam logic [1:0] REG_STABLE = 2'd2;

    function automatic t_elem sat_elem(input logic signed [MSUM_W-1:0] v);
        t_elem r;
        if (v > EMAX) r = EMAX[ELEM_W-1:0];
        else if (v < EMIN) r = EMIN[ELEM_W-1:0];
        else r = v[ELEM_W-1:0];
        return r;
    endfunction

    function automatic t_mat identity();
        t_mat m;
        for (int i = 0; i < NELEM; i++) m[i] = '0;
        m[0] = ONE_Q;
        m[4] = ONE_Q;
        m[8] = ONE_Q;
        return m;
    endfunction

    function automatic logic [1:0] mode_code(input t_mode m);
        logic [1:0] c;
        unique case (m)
            MODE_UNINIT: c = GS_UNINIT;
            MODE_TRACK:  c = GS_TRACK;
            MODE_HOLD:   c = GS_HOLD;
            MODE_REACQ:  c = GS_REACQ;
            default:     c = GS_UNINIT;
        endcase
        return c;
    endfunction

endpackage

// ----- rtl/rog_matmul.sv -----
// 3x3 fixed-point matrix product a*b or a*b^T with round and saturate
module rog_matmul
    import rog_pkg::*;
(
    input  t_mat i_a,
    input  t_mat i_b,
    input  logic i_tb,
    output t_mat o_y
);

    always_comb begin
        logic signed [MSUM_W-1:0] acc;
        logic signed [MSUM_W-1:0] sh;
        logic signed [PROD_W-1:0] prod;
        t_elem bv;
        for (int c = 0; c < 3; c++) begin
            for (int r = 0; r < 3; r++) begin
                acc = HALF;
                for (int k = 0; k < 3; k++) begin
                    bv = i_tb ? i_b[k*3+c] : i_b[c*3+k];
                    prod = $signed(i_a[k*3+r]) * $signed(bv);
                    acc = acc + MSUM_W'(prod);
                end
                // drop the fraction bits; with the HALF preload this rounds to nearest
                sh = acc >>> FRAC;
                o_y[c*3+r] = sat_elem(sh);
            end
        end
    end

endmodule

// ----- rtl/rotation_outlier_gate_top.sv -----
// top level of the rotation outlier gate: stream ports, config, gate state
// a result passes the input register, then the result register
// throughput: one item per cycle while the result is not stalled; trace compare and matrix products are combinational
// a stalled result holds one item in the output register, one more waits in the input register
// reset is synchronous active low: gate returns to uninitialized, all matrices identity
// registers reset to limit 16384, budget 5, stable needed 3
module rotation_outlier_gate_top
    import rog_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [ELEM_W*NELEM-1:0] s_axis_tdata,  // m00,m01,m02,m10,m11,m12,m20,m21,m22
    input  logic [2:0]            s_axis_tuser,  // op[1:0], obs_valid[2]
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [ELEM_W*NELEM-1:0] m_axis_tdata,  // r00,r01,r02,r10,r11,r12,r20,r21,r22
    output logic [5:0]            m_axis_tuser,  // publish[1:0], gate_state[3:2], rejection[5:4]
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [3:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    // config registers
    logic signed [LIMIT_W-1:0] r_limit;
    logic [3:0] r_budget;
    logic [2:0] r_stable;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit  <= LIMIT_W'(16384);
            r_budget <= 4'd5;
            r_stable <= 3'd3;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                REG_LIMIT:  r_limit  <= pwdata[LIMIT_W-1:0];
                REG_BUDGET: r_budget <= pwdata[3:0];
                REG_STABLE: r_stable <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    assign pready = 1'b1;

    always_comb begin
        unique case (paddr[3:2])
            REG_LIMIT:  prdata = {{(32-LIMIT_W){r_limit[LIMIT_W-1]}}, r_limit};
            REG_BUDGET: prdata = {28'd0, r_budget};
            REG_STABLE: prdata = {29'd0, r_stable};
            default:    prdata = '0;
        endcase
    end

    // input register
    logic       r_in_vld;
    logic [1:0] r_in_op;
    logic       r_in_ok;
    t_mat       r_in_m;
    logic       r_out_vld;
    logic       adv;

    assign adv = r_in_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_in_vld || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_op <= s_axis_tuser[1:0];
            r_in_ok <= s_axis_tuser[2];
            for (int i = 0; i < NELEM; i++) r_in_m[i] <= s_axis_tdata[i*ELEM_W +: ELEM_W];
        end
    end

    // gate state
    t_mode      r_mode, n_mode;
    t_mat       r_araw, n_araw;
    t_mat       r_aeff, n_aeff;
    t_mat       r_rebase, n_rebase;
    t_mat       r_cand, n_cand;
    logic [2:0] r_sc, n_sc;
    logic [4:0] r_oc, n_oc;

    // matrix products: forward rebase*obs, reverse anchor*obs^T
    t_mat fwd_m, rev_m;

    rog_matmul u_fwd (.i_a(r_rebase), .i_b(r_in_m), .i_tb(1'b0), .o_y(fwd_m));
    rog_matmul u_rev (.i_a(r_aeff),   .i_b(r_in_m), .i_tb(1'b1), .o_y(rev_m));

    // trace of prev^T*obs against the limit
    logic jump;
    always_comb begin
        logic signed [TSUM_W-1:0] tsum;
        logic signed [TSUM_W-1:0] tsh;
        logic signed [PROD_W-1:0] tprod;
        t_elem pv;
        tsum = '0;
        for (int i = 0; i < NELEM; i++) begin
            pv = (r_mode == MODE_REACQ) ? r_cand[i] : r_araw[i];
            tprod = $signed(pv) * $signed(r_in_m[i]);
            tsum = tsum + TSUM_W'(tprod);
        end
        tsh = tsum >>> FRAC;
        jump = tsh < $signed({{(TSUM_W-LIMIT_W){r_limit[LIMIT_W-1]}}, r_limit});
    end

    // next state and result
    logic [1:0] pub, rej;
    t_mat       pub_m;
    logic [2:0] sc_inc;
    logic [4:0] oc_inc;

    always_comb begin
        n_mode   = r_mode;
        n_araw   = r_araw;
        n_aeff   = r_aeff;
        n_rebase = r_rebase;
        n_cand   = r_cand;
        n_sc     = r_sc;
        n_oc     = r_oc;
        pub      = PUB_HELD;
        rej      = REJ_NONE;
        for (int i = 0; i < NELEM; i++) pub_m[i] = '0;
        sc_inc = (r_sc < 3'd7) ? r_sc + 3'd1 : r_sc;
        oc_inc = r_oc + 5'd1;
        priority if (r_in_op == OP_REACQ) begin
            if (r_mode != MODE_UNINIT) begin
                n_mode = MODE_HOLD;
                n_sc   = '0;
                n_oc   = '0;
            end
        end else if (r_in_op == OP_SRST) begin
            n_mode   = MODE_UNINIT;
            n_araw   = identity();
            n_aeff   = identity();
            n_rebase = identity();
            n_cand   = identity();
            n_sc     = '0;
            n_oc     = '0;
        end else if (r_in_op == OP_OBS) begin
            if (!r_in_ok) begin
                rej    = REJ_INVAL;
                n_mode = MODE_HOLD;
                n_sc   = '0;
                n_oc   = '0;
            end else begin
                unique case (r_mode)
                    MODE_UNINIT: begin
                        n_araw   = r_in_m;
                        n_aeff   = r_in_m;
                        n_rebase = identity();
                        n_oc     = '0;
                        n_mode   = MODE_TRACK;
                        pub      = PUB_TRACK;
                        pub_m    = r_in_m;
                    end
                    MODE_TRACK: begin
                        if (jump) begin
                            rej  = REJ_JUMP;
                            n_oc = oc_inc;
                            if (oc_inc > {1'b0, r_budget}) begin
                                n_oc   = '0;
                                n_mode = MODE_HOLD;
                                n_sc   = '0;
                            end
                        end else begin
                            n_oc   = '0;
                            n_araw = r_in_m;
                            n_aeff = fwd_m;
                            pub    = PUB_TRACK;
                            pub_m  = fwd_m;
                        end
                    end
                    MODE_HOLD: begin
                        n_cand   = r_in_m;
                        n_rebase = rev_m;
                        n_sc     = 3'd1;
                        n_mode   = MODE_REACQ;
                    end
                    MODE_REACQ: begin
                        n_cand = r_in_m;
                        if (jump) begin
                            rej      = REJ_JUMP;
                            n_rebase = rev_m;
                            n_sc     = 3'd1;
                        end else begin
                            n_sc = sc_inc;
                            if (sc_inc >= r_stable) begin
                                n_araw = r_in_m;
                                n_aeff = fwd_m;
                                n_mode = MODE_TRACK;
                                pub    = PUB_REACQ;
                                pub_m  = fwd_m;
                            end
                        end
                    end
                    default: ;
                endcase
            end
        end else begin
            // unused op leaves everything as is
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_UNINIT;
            r_araw   <= identity();
            r_aeff   <= identity();
            r_rebase <= identity();
            r_cand   <= identity();
            r_sc     <= '0;
            r_oc     <= '0;
        end else if (adv) begin
            r_mode   <= n_mode;
            r_araw   <= n_araw;
            r_aeff   <= n_aeff;
            r_rebase <= n_rebase;
            r_cand   <= n_cand;
            r_sc     <= n_sc;
            r_oc     <= n_oc;
        end
    end

    // result register
    logic [5:0]             r_out_user;
    logic [ELEM_W*NELEM-1:0] r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_user <= {rej, mode_code(n_mode), pub};
            for (int i = 0; i < NELEM; i++) r_out_data[i*ELEM_W +: ELEM_W] <= pub_m[i];
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tuser  = r_out_user;
    assign m_axis_tdata  = r_out_data;

endmodule

// ----- rtl/rog_checker.sv -----
// port-level checks of the rotation outlier gate and their binding
module rog_checker
    import rog_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [ELEM_W*NELEM-1:0] m_axis_tdata,
    input logic [5:0]             m_axis_tuser
);

    // a held result carries a zero matrix
    a_held_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1:0] == PUB_HELD |-> m_axis_tdata == '0)
        else $error("held result with nonzero matrix");

    // a rejected frame is never published
    a_rej_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[5:4] != REJ_NONE |-> m_axis_tuser[1:0] == PUB_HELD)
        else $error("rejected frame published");

    // publishing only happens in tracking
    a_pub_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1:0] != PUB_HELD |-> m_axis_tuser[3:2] == GS_TRACK)
        else $error("published outside tracking");

    // a stalled result transfer holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

endmodule

bind rotation_outlier_gate_top rog_checker u_rog_checker (.*);
